// ===== design/convex_polyhedron_containment_unit_macros.svh =====
// Assertion macros for the convex polyhedron containment unit
`ifndef CONVEX_POLYHEDRON_CONTAINMENT_UNIT_MACROS_SVH
`define CONVEX_POLYHEDRON_CONTAINMENT_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define CPC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cpc_pkg.sv =====
// Shared types and constants of the convex polyhedron containment unit
`default_nettype none

package cpc_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 20;
   localparam int NORM_W     = 22;
   localparam int SLOT_W     = 5;
   localparam int COUNT_W    = 6;
   localparam int CSR_IDX_W  = 3;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = DIFF_W + NORM_W;
   localparam int SUM_W  = PROD_W + 2;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_POINT = 2'd1;
   localparam logic [1:0] OP_BOX   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_X      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Z      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SHAPE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_COUNT = 3'd7;

   localparam logic signed [COORD_BITS-1:0] BOUND_ONE = COORD_BITS'(1 << FRAC_BITS);
   localparam logic [COUNT_W-1:0]           FACE_COUNT_RST = 6'd12;

   // tolerance of one LSB, as signed differences
   localparam logic signed [DIFF_W-1:0] TOL_POS = DIFF_W'(1);
   localparam logic signed [DIFF_W-1:0] TOL_NEG = '1;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [SLOT_W-1:0]            face_slot;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic signed [COORD_BITS-1:0] bz;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic was_box_query;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] min_z;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] max_y;
      logic signed [COORD_BITS-1:0] max_z;
      logic                         box_shape;
      logic [COUNT_W-1:0]           face_count;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vx;
      logic signed [COORD_BITS-1:0] vy;
      logic signed [COORD_BITS-1:0] vz;
      logic signed [NORM_W-1:0]     nx;
      logic signed [NORM_W-1:0]     ny;
      logic signed [NORM_W-1:0]     nz;
   } face_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic busy;
      logic neg_valid;
      logic neg;
   } dot_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUND,
      ST_CORNER,
      ST_WALK,
      ST_REPLY
   } seq_state_type;

endpackage

`default_nettype wire

// ===== design/convex_polyhedron_containment_unit.sv =====
// Top level of the convex polyhedron containment unit
// Loads face entries (vertex and unit normal) into a table and answers point
// and box containment queries, one item at a time. A load or an unused opcode
// gives no result. A query is tested against the configured bounding box (one
// LSB tolerance); with box_shape clear it then walks the face table one entry
// per cycle through the single read port of the face memory, a box query
// walking the table once per corner. Results sit in an output register; the
// next item is taken while a result still waits. Configuration writes are
// always taken and must only be made while no query is in progress.
`default_nettype none

module convex_polyhedron_containment_unit import cpc_pkg::*; #(
   parameter int MAX_FACES = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_FACES);

   function automatic logic signed [NORM_W-1:0] sat_norm(
      input logic signed [COORD_BITS-1:0] v);
      logic [COORD_BITS-NORM_W:0] top;
      top = v[COORD_BITS-1:NORM_W-1];
      if (top == '0 || top == '1) return v[NORM_W-1:0];
      return v[COORD_BITS-1] ? {1'b1, {(NORM_W-1){1'b0}}} : {1'b0, {(NORM_W-1){1'b1}}};
   endfunction

   cfg_type       cfg_ff, cfg_in;
   face_word_type wr_data, rd_data;
   point_type     pt;
   dot_stat_type  dot;
   logic          wr_en, rd_en, rd_pend;
   logic [AW-1:0] rd_addr;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_X:      cfg_in.min_x      = csr_wdata;
            CSR_MIN_Y:      cfg_in.min_y      = csr_wdata;
            CSR_MIN_Z:      cfg_in.min_z      = csr_wdata;
            CSR_MAX_X:      cfg_in.max_x      = csr_wdata;
            CSR_MAX_Y:      cfg_in.max_y      = csr_wdata;
            CSR_MAX_Z:      cfg_in.max_z      = csr_wdata;
            CSR_BOX_SHAPE:  cfg_in.box_shape  = csr_wdata[0];
            CSR_FACE_COUNT: cfg_in.face_count = csr_wdata[COUNT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{min_x: '0, min_y: '0, min_z: '0,
                     max_x: BOUND_ONE, max_y: BOUND_ONE, max_z: BOUND_ONE,
                     box_shape: 1'b1, face_count: FACE_COUNT_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // loads with a slot inside the table write straight into it on the transfer
   assign wr_en = req_valid && !req_stall && req_payload.opcode == OP_LOAD &&
                  32'(req_payload.face_slot) < 32'(MAX_FACES);

   assign wr_data = '{vx: req_payload.ax, vy: req_payload.ay, vz: req_payload.az,
                      nx: sat_norm(req_payload.bx), ny: sat_norm(req_payload.by),
                      nz: sat_norm(req_payload.bz)};

   cpc_face_mem #(.MAX_FACES(MAX_FACES)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_payload.face_slot)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpc_dot_unit u_dot (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_pend),
      .face     (rd_data),
      .pt       (pt),
      .stat     (dot)
   );

   cpc_seq #(.MAX_FACES(MAX_FACES)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cfg         (cfg_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .pt          (pt),
      .rd_pend     (rd_pend),
      .dot         (dot)
   );

endmodule

`default_nettype wire

// ===== design/cpc_face_mem.sv =====
// Face table memory: one write port, one registered read port
`default_nettype none

module cpc_face_mem import cpc_pkg::*; #(
   parameter int MAX_FACES = 32
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MAX_FACES)-1:0] wr_addr,
   input  wire face_word_type                wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(MAX_FACES)-1:0] rd_addr,
   output face_word_type                     rd_data
);

   face_word_type mem_ff [MAX_FACES];
   face_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/cpc_dot_unit.sv =====
// Pipelined exact sign test of dot(vertex - point, normal), one face per cycle
`default_nettype none

module cpc_dot_unit import cpc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire face_word_type face,
   input  wire point_type     pt,
   output dot_stat_type       stat
);

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [NORM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic                     neg_ff;

   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic signed [PROD_W-1:0] px_in, py_in, pz_in;
   logic signed [SUM_W-1:0]  sum;

   assign dx_in = DIFF_W'(face.vx) - DIFF_W'(pt.x);
   assign dy_in = DIFF_W'(face.vy) - DIFF_W'(pt.y);
   assign dz_in = DIFF_W'(face.vz) - DIFF_W'(pt.z);

   assign px_in = PROD_W'(dx_ff) * PROD_W'(nx_ff);
   assign py_in = PROD_W'(dy_ff) * PROD_W'(ny_ff);
   assign pz_in = PROD_W'(dz_ff) * PROD_W'(nz_ff);

   assign sum = SUM_W'(px_ff) + SUM_W'(py_ff) + SUM_W'(pz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      dz_ff  <= dz_in;
      nx_ff  <= face.nx;
      ny_ff  <= face.ny;
      nz_ff  <= face.nz;
      px_ff  <= px_in;
      py_ff  <= py_in;
      pz_ff  <= pz_in;
      neg_ff <= sum[SUM_W-1];
   end

   assign stat.busy      = v1_ff | v2_ff | v3_ff;
   assign stat.neg_valid = v3_ff;
   assign stat.neg       = neg_ff;

endmodule

`default_nettype wire

// ===== design/cpc_seq.sv =====
// Query sequencer: bounding box checks, corner walk, face reads, result register
`default_nettype none

module cpc_seq import cpc_pkg::*; #(
   parameter int MAX_FACES = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire req_type                      req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output rsp_type                           rsp_payload,
   input  wire cfg_type                      cfg,
   output logic                              rd_en,
   output logic [$clog2(MAX_FACES)-1:0]      rd_addr,
   output point_type                         pt,
   output logic                              rd_pend,
   input  wire dot_stat_type                 dot
);

   localparam int AW    = $clog2(MAX_FACES);
   localparam int CNT_W = $clog2(MAX_FACES + 1);

   function automatic logic above_min(input logic signed [COORD_BITS-1:0] lim,
                                      input logic signed [COORD_BITS-1:0] p);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(lim) - DIFF_W'(p);
      return d <= TOL_POS;
   endfunction

   function automatic logic below_max(input logic signed [COORD_BITS-1:0] lim,
                                      input logic signed [COORD_BITS-1:0] p);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(lim) - DIFF_W'(p);
      return d >= TOL_NEG;
   endfunction

   function automatic logic in_bounds(input cfg_type c, input point_type lo,
                                      input point_type hi);
      return above_min(c.min_x, lo.x) && above_min(c.min_y, lo.y) &&
             above_min(c.min_z, lo.z) && below_max(c.max_x, hi.x) &&
             below_max(c.max_y, hi.y) && below_max(c.max_z, hi.z);
   endfunction

   seq_state_type    state_ff, state_in;
   req_type          item_ff, item_in;
   point_type        pt_ff, pt_in;
   logic [2:0]       corner_ff, corner_in;
   logic [CNT_W-1:0] face_ff, face_in;
   logic             fail_ff, fail_in;
   logic             inside_ff, inside_in;
   logic             rd_pend_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             acc, is_query, is_box, out_free, last_corner, walk_done;
   logic             pre_ok, corner_ok;
   logic [CNT_W-1:0] eff_cnt;
   point_type        pa, pb, phi, cp;

   assign acc      = req_valid && !req_stall;
   assign is_query = req_payload.opcode == OP_POINT || req_payload.opcode == OP_BOX;
   assign is_box   = item_ff.opcode == OP_BOX;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign eff_cnt = (32'(cfg.face_count) > 32'(MAX_FACES)) ? CNT_W'(MAX_FACES)
                                                             : CNT_W'(cfg.face_count);

   assign pa  = '{x: item_ff.ax, y: item_ff.ay, z: item_ff.az};
   assign pb  = '{x: item_ff.bx, y: item_ff.by, z: item_ff.bz};
   assign phi = is_box ? pb : pa;
   assign cp  = '{x: (is_box && corner_ff[0]) ? item_ff.bx : item_ff.ax,
                  y: (is_box && corner_ff[1]) ? item_ff.by : item_ff.ay,
                  z: (is_box && corner_ff[2]) ? item_ff.bz : item_ff.az};

   assign pre_ok      = in_bounds(cfg, pa, phi);
   assign corner_ok   = in_bounds(cfg, cp, cp);
   assign last_corner = !is_box || corner_ff == 3'd7;
   assign walk_done   = face_ff == eff_cnt && !rd_pend_ff && !dot.busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && is_query) state_in = ST_BOUND;
         end
         ST_BOUND: begin
            if (!pre_ok || cfg.box_shape) state_in = ST_REPLY;
            else                          state_in = ST_CORNER;
         end
         ST_CORNER: begin
            state_in = corner_ok ? ST_WALK : ST_REPLY;
         end
         ST_WALK: begin
            if (walk_done) begin
               if (fail_ff || last_corner) state_in = ST_REPLY;
               else                        state_in = ST_CORNER;
            end
         end
         ST_REPLY: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_in      = acc ? req_payload : item_ff;
      pt_in        = pt_ff;
      corner_in    = corner_ff;
      face_in      = face_ff;
      fail_in      = fail_ff;
      inside_in    = inside_ff;
      rd_en        = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_BOUND: begin
            inside_in = pre_ok;
            corner_in = 3'd0;
         end
         ST_CORNER: begin
            inside_in = corner_ok;
            pt_in     = cp;
            face_in   = '0;
            fail_in   = 1'b0;
         end
         ST_WALK: begin
            rd_en = face_ff != eff_cnt;
            if (rd_en) face_in = face_ff + CNT_W'(1);
            if (dot.neg_valid && dot.neg) fail_in = 1'b1;
            if (walk_done) begin
               inside_in = !fail_ff;
               corner_in = corner_ff + 3'd1;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{inside_res: inside_ff, was_box_query: is_box};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         corner_ff    <= 3'd0;
         face_ff      <= '0;
         fail_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         corner_ff    <= corner_in;
         face_ff      <= face_in;
         fail_ff      <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      pt_ff     <= pt_in;
      inside_ff <= inside_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rd_addr     = face_ff[AW-1:0];
   assign pt          = pt_ff;
   assign rd_pend     = rd_pend_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== design/cpc_checker.sv =====
// Port-level checks of the containment unit and their bind
`default_nettype none

`include "convex_polyhedron_containment_unit_macros.svh"

module cpc_checker import cpc_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire req_type               req_payload,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire rsp_type               rsp_payload
);

   logic req_xfer, query_xfer, load_xfer;

   assign req_xfer   = req_valid && !req_stall;
   assign query_xfer = req_xfer &&
                       (req_payload.opcode == OP_POINT || req_payload.opcode == OP_BOX);
   assign load_xfer  = req_xfer && req_payload.opcode == OP_LOAD;

   `CPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "result changed while stalled")
   `CPC_ASSERT_NEXT(a_query_busy, query_xfer, req_stall, "query transfer not followed by busy")
   `CPC_ASSERT_NEXT(a_load_one_cycle, load_xfer, !req_stall, "load did not finish in one cycle")
   `CPC_ASSERT_NOW(a_rsp_after_query, $rose(rsp_valid), $past(req_stall), "result without a query in progress")

endmodule

bind convex_polyhedron_containment_unit cpc_checker u_cpc_checker (.*);

`default_nettype wire

// ===== test/tb_convex_polyhedron_containment_unit.sv =====
// Self-checking testbench of the convex polyhedron containment unit: face loads and queries
`default_nettype none

module tb_convex_polyhedron_containment_unit;
   import cpc_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int TABLE_DEPTH = 32;
   localparam int SETTLE_CYCLES = 320;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 67;
   localparam int ONE = 1 << FRAC_BITS;
   localparam longint NORM_HI = 2097151;
   localparam longint NORM_LO = -2097152;
   localparam longint COORD_HI = (longint'(1) << 31) - 1;
   localparam longint COORD_LO = -(longint'(1) << 31);

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_BITS-1:0] csr_wdata = '0;

   cfg_type shadow_cfg;
   face_word_type face_table [TABLE_DEPTH];
   rsp_type awaited_answers [$];
   req_type item_backlog [$];
   int mismatch_count = 0;
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;
   int gap_left = 0;
   longint solid_cx = 0, solid_cy = 0, solid_cz = 0, solid_r = ONE;

   convex_polyhedron_containment_unit #(.MAX_FACES(TABLE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   initial begin
      #24000000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic void backlog_add(req_type r);
      item_backlog.insert(item_backlog.size(), r);
   endfunction

   function automatic longint sx(logic [COORD_BITS-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint sn(logic [NORM_W-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic logic [NORM_W-1:0] clamp_normal(logic [COORD_BITS-1:0] v);
      longint s = sx(v);
      if (s > NORM_HI) return NORM_W'(NORM_HI);
      if (s < NORM_LO) return NORM_W'(NORM_LO);
      return NORM_W'(s);
   endfunction

   // bounding box test, one LSB of slack on each side
   function automatic logic within_bounds(longint lx, longint ly, longint lz,
                                          longint hx, longint hy, longint hz);
      return (sx(shadow_cfg.min_x) - lx) <= 1 && (sx(shadow_cfg.min_y) - ly) <= 1 &&
             (sx(shadow_cfg.min_z) - lz) <= 1 && (sx(shadow_cfg.max_x) - hx) >= -1 &&
             (sx(shadow_cfg.max_y) - hy) >= -1 && (sx(shadow_cfg.max_z) - hz) >= -1;
   endfunction

   function automatic logic point_inside(longint px, longint py, longint pz);
      int unsigned faces_used;
      longint dot;
      if (!within_bounds(px, py, pz, px, py, pz)) return 1'b0;
      if (shadow_cfg.box_shape) return 1'b1;
      faces_used = (shadow_cfg.face_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_cfg.face_count;
      for (int f = 0; f < faces_used; f++) begin
         dot = (sx(face_table[f].vx) - px) * sn(face_table[f].nx) +
               (sx(face_table[f].vy) - py) * sn(face_table[f].ny) +
               (sx(face_table[f].vz) - pz) * sn(face_table[f].nz);
         if (dot < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic box_inside(longint x0, longint y0, longint z0,
                                       longint x1, longint y1, longint z1);
      if (!within_bounds(x0, y0, z0, x1, y1, z1)) return 1'b0;
      if (shadow_cfg.box_shape) return 1'b1;
      return point_inside(x0, y0, z0) && point_inside(x1, y1, z1) &&
             point_inside(x1, y0, z0) && point_inside(x1, y0, z1) &&
             point_inside(x1, y1, z0) && point_inside(x0, y1, z0) &&
             point_inside(x0, y1, z1) && point_inside(x0, y0, z1);
   endfunction

   function automatic void predict_containment(req_type r);
      rsp_type answer;
      case (r.opcode)
         OP_LOAD: begin
            face_table[r.face_slot] = '{vx: r.ax, vy: r.ay, vz: r.az, nx: clamp_normal(r.bx),
                                        ny: clamp_normal(r.by), nz: clamp_normal(r.bz)};
         end
         OP_POINT: begin
            answer.inside_res = point_inside(sx(r.ax), sx(r.ay), sx(r.az));
            answer.was_box_query = 1'b0;
            awaited_answers.insert(awaited_answers.size(), answer);
         end
         OP_BOX: begin
            answer.inside_res = box_inside(sx(r.ax), sx(r.ay), sx(r.az),
                                           sx(r.bx), sx(r.by), sx(r.bz));
            answer.was_box_query = 1'b1;
            awaited_answers.insert(awaited_answers.size(), answer);
         end
         default: ;
      endcase
   endfunction

   function automatic void shadow_write(logic [CSR_IDX_W-1:0] idx, logic [COORD_BITS-1:0] v);
      case (idx)
         CSR_MIN_X: shadow_cfg.min_x = v;
         CSR_MIN_Y: shadow_cfg.min_y = v;
         CSR_MIN_Z: shadow_cfg.min_z = v;
         CSR_MAX_X: shadow_cfg.max_x = v;
         CSR_MAX_Y: shadow_cfg.max_y = v;
         CSR_MAX_Z: shadow_cfg.max_z = v;
         CSR_BOX_SHAPE: shadow_cfg.box_shape = v[0];
         CSR_FACE_COUNT: shadow_cfg.face_count = v[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic req_type make_item(logic [1:0] op, int unsigned slot,
                                         longint ax, longint ay, longint az,
                                         longint bx, longint by, longint bz);
      req_type r;
      r.opcode = op;
      r.face_slot = SLOT_W'(slot);
      r.ax = COORD_BITS'(ax);
      r.ay = COORD_BITS'(ay);
      r.az = COORD_BITS'(az);
      r.bx = COORD_BITS'(bx);
      r.by = COORD_BITS'(by);
      r.bz = COORD_BITS'(bz);
      return r;
   endfunction

   // unit cube faces; later slots repeat them with normals far outside the stored range
   function automatic req_type cube_face(int unsigned slot);
      int unsigned axis = (slot % 6) / 2;
      bit outer = slot[0];
      longint v[3];
      longint n[3];
      for (int k = 0; k < 3; k++) begin
         v[k] = $urandom_range(0, ONE);
         n[k] = 0;
      end
      v[axis] = outer ? ONE : 0;
      if (slot < 6)
         n[axis] = outer ? ONE : -ONE;
      else if (slot < 12)
         n[axis] = outer ? COORD_HI : COORD_LO;
      else
         n[axis] = outer ? longint'($urandom_range(NORM_HI, 32'h7fffffff))
                         : -longint'($urandom_range(-NORM_LO, 32'h80000000));
      return make_item(OP_LOAD, slot, v[0], v[1], v[2], n[0], n[1], n[2]);
   endfunction

   // tangent plane of the current solid: centre stays inside
   function automatic req_type solid_face(int unsigned slot);
      longint nx = longint'($urandom_range(0, 2 * ONE)) - ONE;
      longint ny = longint'($urandom_range(0, 2 * ONE)) - ONE;
      longint nz = longint'($urandom_range(0, 2 * ONE)) - ONE;
      longint boost = ($urandom_range(0, 7) == 0) ? 4 : 1;
      return make_item(OP_LOAD, slot, solid_cx + ((nx * solid_r) >>> FRAC_BITS),
                       solid_cy + ((ny * solid_r) >>> FRAC_BITS),
                       solid_cz + ((nz * solid_r) >>> FRAC_BITS),
                       nx * boost, ny * boost, nz * boost);
   endfunction

   function automatic longint pick_coord(longint lo, longint hi, longint c);
      int unsigned roll = $urandom_range(0, 99);
      if (roll < 70) return c + (longint'($urandom_range(0, 3000)) - 1500) * solid_r / 1000;
      if (roll < 86) return ((roll % 2) ? hi : lo) + longint'($urandom_range(0, 4)) - 2;
      return sx($urandom());
   endfunction

   function automatic longint box_far(longint a, longint lo, longint hi, longint c);
      if ($urandom_range(0, 1)) return a + longint'($urandom_range(0, 1000)) * solid_r / 1000;
      return pick_coord(lo, hi, c);
   endfunction

   function automatic req_type random_item();
      int unsigned roll = $urandom_range(0, 99);
      int unsigned slot = $urandom_range(0, TABLE_DEPTH - 1);
      longint x0, y0, z0;
      x0 = pick_coord(sx(shadow_cfg.min_x), sx(shadow_cfg.max_x), solid_cx);
      y0 = pick_coord(sx(shadow_cfg.min_y), sx(shadow_cfg.max_y), solid_cy);
      z0 = pick_coord(sx(shadow_cfg.min_z), sx(shadow_cfg.max_z), solid_cz);
      if (roll < 22) return solid_face(slot);
      if (roll < 57)
         return make_item(OP_POINT, slot, x0, y0, z0, sx($urandom()), sx($urandom()),
                          sx($urandom()));
      if (roll < 87)
         return make_item(OP_BOX, slot, x0, y0, z0,
                          box_far(x0, sx(shadow_cfg.min_x), sx(shadow_cfg.max_x), solid_cx),
                          box_far(y0, sx(shadow_cfg.min_y), sx(shadow_cfg.max_y), solid_cy),
                          box_far(z0, sx(shadow_cfg.min_z), sx(shadow_cfg.max_z), solid_cz));
      return make_item((roll < 92) ? OP_SPARE : 2'($urandom()), slot, sx($urandom()),
                       sx($urandom()), sx($urandom()), sx($urandom()), sx($urandom()),
                       sx($urandom()));
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COORD_BITS-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_write(idx, v);
   endtask

   task automatic program_config(longint lo_x, longint lo_y, longint lo_z, longint hi_x,
                                 longint hi_y, longint hi_z, logic shape, int unsigned count);
      write_reg(CSR_MIN_X, COORD_BITS'(lo_x));
      write_reg(CSR_MIN_Y, COORD_BITS'(lo_y));
      write_reg(CSR_MIN_Z, COORD_BITS'(lo_z));
      write_reg(CSR_MAX_X, COORD_BITS'(hi_x));
      write_reg(CSR_MAX_Y, COORD_BITS'(hi_y));
      write_reg(CSR_MAX_Z, COORD_BITS'(hi_z));
      write_reg(CSR_BOX_SHAPE, COORD_BITS'(shape));
      write_reg(CSR_FACE_COUNT, COORD_BITS'(count));
      @(negedge clock) csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // returns on a rising edge once nothing is queued, offered or outstanding
   task automatic drain(int unsigned settle);
      while (item_backlog.size() != 0 || req_valid || awaited_answers.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // request side: prediction on each transfer, next item offered at the falling edge
   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) predict_containment(req_payload);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (req_fired) gap_left = send_burst ? 0 : $urandom_range(0, 4);
         if (gap_left == 0 && item_backlog.size() != 0) begin
            req_payload <= item_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // result side
   always @(posedge clock) begin
      rsp_type want;
      rsp_fired <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_answers.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: result with none pending: inside=%0b box=%0b", $time,
                        rsp_payload.inside_res, rsp_payload.was_box_query);
            mismatch_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (want.inside_res !== rsp_payload.inside_res ||
                want.was_box_query !== rsp_payload.was_box_query) begin
               if (mismatch_count < 10)
                  $display("%0t: expected inside=%0b box=%0b, got inside=%0b box=%0b", $time,
                           want.inside_res, want.was_box_query, rsp_payload.inside_res,
                           rsp_payload.was_box_query);
               mismatch_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_fired) stall_left = recv_burst ? 0 : $urandom_range(0, 4);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            if (rsp_valid) stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int unsigned counts [PHASES] = '{32, 6, 63, 1, 12, 33, 0, 32, 20};
      longint lo [3];
      longint hi [3];
      longint c [3];
      logic shape;
      shadow_cfg.min_x = '0;
      shadow_cfg.min_y = '0;
      shadow_cfg.min_z = '0;
      shadow_cfg.max_x = BOUND_ONE;
      shadow_cfg.max_y = BOUND_ONE;
      shadow_cfg.max_z = BOUND_ONE;
      shadow_cfg.box_shape = 1'b1;
      shadow_cfg.face_count = FACE_COUNT_RST;
      wait (!reset);
      @(posedge clock);

      // bounding box only, reset settings
      backlog_add(make_item(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
      backlog_add(make_item(OP_POINT, 31, -1, -1, -1, COORD_HI, COORD_LO, 0));
      backlog_add(make_item(OP_POINT, 0, -2, 0, 0, 0, 0, 0));
      backlog_add(make_item(OP_POINT, 0, ONE + 1, ONE + 1, ONE + 1, 0, 0, 0));
      backlog_add(make_item(OP_POINT, 0, ONE, ONE, ONE + 2, 0, 0, 0));
      backlog_add(make_item(OP_POINT, 0, COORD_HI, COORD_HI, COORD_HI, 0, 0, 0));
      backlog_add(make_item(OP_POINT, 0, COORD_LO, COORD_LO, COORD_LO, 0, 0, 0));
      backlog_add(make_item(OP_BOX, 0, 0, 0, 0, ONE, ONE, ONE));
      backlog_add(make_item(OP_BOX, 0, -1, -1, -1, ONE + 1, ONE + 1, ONE + 1));
      backlog_add(make_item(OP_BOX, 0, 0, 0, 0, ONE + 2, ONE, ONE));
      backlog_add(make_item(OP_BOX, 0, ONE, ONE, ONE, 0, 0, 0));
      backlog_add(make_item(OP_BOX, 0, COORD_LO, COORD_LO, COORD_LO,
                            COORD_HI, COORD_HI, COORD_HI));
      backlog_add(make_item(OP_SPARE, 31, -1, -1, -1, -1, -1, -1));
      for (int s = 0; s < TABLE_DEPTH; s++) backlog_add(cube_face(s));
      drain(SETTLE_CYCLES);

      // unit cube decided by its faces, bounds well clear
      program_config(-4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 1'b0, 32);
      backlog_add(make_item(OP_POINT, 0, ONE / 2, ONE / 2, ONE / 2, 0, 0, 0));
      backlog_add(make_item(OP_POINT, 0, ONE, ONE / 2, ONE / 2, 0, 0, 0));
      backlog_add(make_item(OP_POINT, 0, ONE + 1, ONE / 2, ONE / 2, 0, 0, 0));
      backlog_add(make_item(OP_POINT, 0, ONE / 2, -1, ONE / 2, 0, 0, 0));
      backlog_add(make_item(OP_BOX, 0, 0, 0, 0, ONE, ONE, ONE));
      backlog_add(make_item(OP_BOX, 0, 0, 0, 0, ONE, ONE + 1, ONE));
      backlog_add(make_item(OP_BOX, 0, ONE / 4, ONE / 4, ONE / 4,
                            3 * ONE / 4, 3 * ONE / 4, 3 * ONE / 4));
      backlog_add(make_item(OP_BOX, 0, ONE, ONE, ONE, 0, 0, 0));
      backlog_add(make_item(OP_BOX, 0, ONE, ONE, ONE + 1, 0, 0, 0));
      drain(SETTLE_CYCLES);

      // no faces tested, then a count beyond the table
      program_config(-4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 1'b0, 0);
      backlog_add(make_item(OP_POINT, 0, 3 * ONE, ONE / 2, ONE / 2, 0, 0, 0));
      backlog_add(make_item(OP_BOX, 0, -3 * ONE, -3 * ONE, -3 * ONE,
                            3 * ONE, 3 * ONE, 3 * ONE));
      drain(SETTLE_CYCLES);
      program_config(-4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 1'b0, 63);
      backlog_add(make_item(OP_POINT, 0, 3 * ONE, ONE / 2, ONE / 2, 0, 0, 0));
      backlog_add(make_item(OP_BOX, 0, -3 * ONE, -3 * ONE, -3 * ONE,
                            3 * ONE, 3 * ONE, 3 * ONE));
      backlog_add(make_item(OP_POINT, 0, ONE / 2, ONE / 2, ONE / 2, 0, 0, 0));
      drain(SETTLE_CYCLES);

      for (int p = 0; p < PHASES; p++) begin
         solid_cx = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
         solid_cy = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
         solid_cz = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
         solid_r = (longint'(1) << $urandom_range(12, 25)) + $urandom_range(0, 4095);
         c[0] = solid_cx;
         c[1] = solid_cy;
         c[2] = solid_cz;
         for (int k = 0; k < 3; k++) begin
            case (p % 4)
               0: begin
                  lo[k] = COORD_LO;
                  hi[k] = COORD_HI;
               end
               1: begin
                  lo[k] = c[k] - solid_r * $urandom_range(6, 12) / 8;
                  hi[k] = c[k] + solid_r * $urandom_range(6, 12) / 8;
               end
               2: begin
                  lo[k] = sx($urandom());
                  hi[k] = sx($urandom());
               end
               default: begin
                  lo[k] = c[k] - solid_r / 2;
                  hi[k] = c[k] + solid_r / 2;
               end
            endcase
         end
         shape = (p == 3 || p == 7);
         program_config(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], shape, counts[p]);
         send_burst = (p % 3 == 1);
         recv_burst = (p % 3 == 2);
         for (int s = 0; s < TABLE_DEPTH; s++) backlog_add(solid_face(s));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            backlog_add(random_item());
            // sender waits for every outstanding result half way through
            if (p == 4 && i == PHASE_ITEMS / 2) drain(0);
         end
         // receiver holds off while transfers keep being offered
         if (p == 2 || p == 6) hold_asks++;
         drain(SETTLE_CYCLES);
      end

      if (mismatch_count == 0 && awaited_answers.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/cpc_pkg.sv
design/cpc_face_mem.sv
design/cpc_dot_unit.sv
design/cpc_seq.sv
design/convex_polyhedron_containment_unit.sv
design/cpc_checker.sv
test/tb_convex_polyhedron_containment_unit.sv
